// ===== sv/quaternion_to_euler_angles_macros.svh =====
// Assertion macros for the quaternion to Euler angle converter.
// Needs clk and rst in the scope of each use; no other dependencies.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qte assertion failed");
`define QTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qte assertion failed");
`else
`define QTE_ASSERT_IMPL(label, ante, cons)
`define QTE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/qte_pkg.sv =====
// Shared types and constants for the quaternion to Euler angle converter.
// No dependencies.
`timescale 1ns / 1ps
package qte_pkg;

  localparam int QW   = 32;  // quaternion component width
  localparam int AW   = 38;  // product accumulators
  localparam int CW   = 40;  // CORDIC x / y
  localparam int ZW   = 35;  // CORDIC angle, Q30 radians
  localparam int SQW  = 62;  // square root working width
  localparam int KW   = 5;   // CORDIC step index
  localparam int DTW  = 54;  // scaled angle
  localparam int DRW  = 44;  // reciprocal product
  localparam int SQRT_ITERS = 31;

  localparam logic signed [AW-1:0] ONE_ACC  = 38'sd1073741824;
  localparam logic signed [ZW-1:0] PI_Q30   = 35'sd3373259426;
  localparam logic [17:0]          DEG_NUM  = 18'd146688;
  localparam logic [DTW-1:0]       DEG_HALF = 54'd5368709120;
  localparam logic [19:0]          RECIP10  = 20'd838861;
  localparam logic [16:0]          PITCH_LIM = 17'd23100;
  localparam logic [16:0]          ANGLE_LIM = 17'd46100;

  typedef enum logic [3:0] {
    MUL_WY, MUL_XZ, MUL_YZ, MUL_WX, MUL_XX, MUL_YY,
    MUL_XY, MUL_WZ, MUL_WW, MUL_ZZ, MUL_SS
  } mul_op_t;

  typedef enum logic [1:0] {ANG_PITCH, ANG_ROLL, ANG_YAW} angle_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DRAIN, ST_SQRT, ST_CLOAD, ST_CSTEP,
    ST_DEG1, ST_DEG2, ST_DEG3, ST_FINISH
  } state_t;

  typedef struct packed {
    logic          capture;
    logic          mul_en;
    mul_op_t       mul_op;
    logic          sqrt_step;
    logic          cordic_load;
    logic          cordic_step;
    logic [KW-1:0] cordic_k;
    angle_t        angle;
    logic          deg1;
    logic          deg2;
    logic          deg3;
    logic          out_load;
  } dp_cmd_t;

  // atan(2^-k) in Q30 radians, truncated
  function automatic logic signed [ZW-1:0] atan_entry(input logic [KW-1:0] k);
    logic [31:0] v;
    unique case (k)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000007;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return signed'({3'b000, v});
  endfunction

endpackage

// ===== sv/qte_ctrl.sv =====
// Sequencer for the quaternion to Euler angle converter.
// Depends on qte_pkg and quaternion_to_euler_angles_macros.svh.
`timescale 1ns / 1ps
`include "quaternion_to_euler_angles_macros.svh"
module qte_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              quat_present,
  output logic              out_valid,
  input  logic              out_ready,
  output qte_pkg::dp_cmd_t  cmd
);

  qte_pkg::state_t           state, state_next;
  logic [qte_pkg::KW-1:0]    cnt;
  qte_pkg::mul_op_t          mul_op;
  qte_pkg::angle_t           angle;
  logic                      slot_free;
  logic [3:0]                unit_busy;

  assign slot_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      qte_pkg::ST_IDLE:
        if (in_valid) state_next = quat_present ? qte_pkg::ST_MUL : qte_pkg::ST_FINISH;
      qte_pkg::ST_MUL:
        if (mul_op == qte_pkg::MUL_SS) state_next = qte_pkg::ST_DRAIN;
      qte_pkg::ST_DRAIN: state_next = qte_pkg::ST_SQRT;
      qte_pkg::ST_SQRT:
        if (cnt == qte_pkg::KW'(qte_pkg::SQRT_ITERS - 1)) state_next = qte_pkg::ST_CLOAD;
      qte_pkg::ST_CLOAD: state_next = qte_pkg::ST_CSTEP;
      qte_pkg::ST_CSTEP:
        if (cnt == qte_pkg::KW'(CORDIC_STEPS - 1)) state_next = qte_pkg::ST_DEG1;
      qte_pkg::ST_DEG1: state_next = qte_pkg::ST_DEG2;
      qte_pkg::ST_DEG2: state_next = qte_pkg::ST_DEG3;
      qte_pkg::ST_DEG3:
        state_next = (angle == qte_pkg::ANG_YAW) ? qte_pkg::ST_FINISH : qte_pkg::ST_CLOAD;
      qte_pkg::ST_FINISH:
        if (slot_free) state_next = qte_pkg::ST_IDLE;
      default: state_next = qte_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd             = '0;
    cmd.mul_op      = mul_op;
    cmd.angle       = angle;
    cmd.cordic_k    = cnt;
    in_ready        = (state == qte_pkg::ST_IDLE);
    cmd.capture     = (state == qte_pkg::ST_IDLE) && in_valid;
    cmd.mul_en      = (state == qte_pkg::ST_MUL);
    cmd.sqrt_step   = (state == qte_pkg::ST_SQRT);
    cmd.cordic_load = (state == qte_pkg::ST_CLOAD);
    cmd.cordic_step = (state == qte_pkg::ST_CSTEP);
    cmd.deg1        = (state == qte_pkg::ST_DEG1);
    cmd.deg2        = (state == qte_pkg::ST_DEG2);
    cmd.deg3        = (state == qte_pkg::ST_DEG3);
    cmd.out_load    = (state == qte_pkg::ST_FINISH) && slot_free;
  end

  // state, step counter, product and angle selectors
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= qte_pkg::ST_IDLE;
      cnt    <= '0;
      mul_op <= qte_pkg::MUL_WY;
      angle  <= qte_pkg::ANG_PITCH;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
      if (cmd.capture) begin
        mul_op <= qte_pkg::MUL_WY;
        angle  <= qte_pkg::ANG_PITCH;
      end else begin
        if (cmd.mul_en && mul_op != qte_pkg::MUL_SS)
          mul_op <= qte_pkg::mul_op_t'(mul_op + 4'd1);
        if (cmd.deg3) begin
          unique case (angle)
            qte_pkg::ANG_PITCH: angle <= qte_pkg::ANG_ROLL;
            qte_pkg::ANG_ROLL:  angle <= qte_pkg::ANG_YAW;
            default:            angle <= qte_pkg::ANG_PITCH;
          endcase
        end
      end
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign unit_busy = {cmd.mul_en, cmd.sqrt_step, cmd.cordic_load, cmd.cordic_step};

  `QTE_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state != qte_pkg::ST_IDLE)
  `QTE_ASSERT_IMPL(a_one_unit, 1'b1, $onehot0(unit_busy))
  `QTE_ASSERT_NEXT(a_stall_waits, state == qte_pkg::ST_FINISH && out_valid && !out_ready, state == qte_pkg::ST_FINISH)
  `QTE_ASSERT_IMPL(a_load_free, cmd.out_load, !out_valid || out_ready)

endmodule

// ===== sv/qte_dp.sv =====
// Datapath: shared multiplier, square root, CORDIC, degree scaling, held angles.
// Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  qte_pkg::dp_cmd_t         cmd,
  input  logic signed [31:0]       quat_w,
  input  logic signed [31:0]       quat_x,
  input  logic signed [31:0]       quat_y,
  input  logic signed [31:0]       quat_z,
  output logic signed [15:0]       pitch_deg,
  output logic signed [16:0]       roll_deg,
  output logic signed [16:0]       yaw_deg
);

  localparam int AW = qte_pkg::AW;
  localparam int CW = qte_pkg::CW;
  localparam int ZW = qte_pkg::ZW;

  logic signed [31:0]    qw, qx, qy, qz;
  logic signed [AW-1:0]  acc_s, acc_ry, acc_rx, acc_yy, acc_yx;
  logic signed [31:0]    s_cl;
  logic signed [31:0]    mul_a, mul_b;
  logic signed [63:0]    prod;
  qte_pkg::mul_op_t      mul_tag;
  logic                  tag_v;
  logic signed [AW-1:0]  p1, p2;

  // captured sample
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qw <= quat_w;
      qx <= quat_x;
      qy <= quat_y;
      qz <= quat_z;
    end
  end

  // asin argument clamped to +-1
  always_comb begin
    if (acc_s > qte_pkg::ONE_ACC) s_cl = 32'sd1073741824;
    else if (acc_s < -qte_pkg::ONE_ACC) s_cl = -32'sd1073741824;
    else s_cl = acc_s[31:0];
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd.mul_op)
      qte_pkg::MUL_WY: begin mul_a = qw;   mul_b = qy;   end
      qte_pkg::MUL_XZ: begin mul_a = qx;   mul_b = qz;   end
      qte_pkg::MUL_YZ: begin mul_a = qy;   mul_b = qz;   end
      qte_pkg::MUL_WX: begin mul_a = qw;   mul_b = qx;   end
      qte_pkg::MUL_XX: begin mul_a = qx;   mul_b = qx;   end
      qte_pkg::MUL_YY: begin mul_a = qy;   mul_b = qy;   end
      qte_pkg::MUL_XY: begin mul_a = qx;   mul_b = qy;   end
      qte_pkg::MUL_WZ: begin mul_a = qw;   mul_b = qz;   end
      qte_pkg::MUL_WW: begin mul_a = qw;   mul_b = qw;   end
      qte_pkg::MUL_ZZ: begin mul_a = qz;   mul_b = qz;   end
      qte_pkg::MUL_SS: begin mul_a = s_cl; mul_b = s_cl; end
      default:         begin mul_a = '0;   mul_b = '0;   end
    endcase
  end

  // registered product with its tag
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_v <= 1'b0;
    end else begin
      tag_v <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod    <= mul_a * mul_b;
      mul_tag <= cmd.mul_op;
    end
  end

  // Q30 product, floor shift, and twice that
  assign p1 = {{(AW-34){prod[63]}}, prod[63:30]};
  assign p2 = p1 <<< 1;

  // term accumulation
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc_s  <= '0;
      acc_ry <= '0;
      acc_rx <= qte_pkg::ONE_ACC;
      acc_yy <= '0;
      acc_yx <= '0;
    end else if (tag_v) begin
      unique case (mul_tag)
        qte_pkg::MUL_WY: acc_s  <= acc_s + p2;
        qte_pkg::MUL_XZ: acc_s  <= acc_s - p2;
        qte_pkg::MUL_YZ: acc_ry <= acc_ry + p2;
        qte_pkg::MUL_WX: acc_ry <= acc_ry + p2;
        qte_pkg::MUL_XX: begin acc_rx <= acc_rx - p2; acc_yx <= acc_yx + p1; end
        qte_pkg::MUL_YY: begin acc_rx <= acc_rx - p2; acc_yx <= acc_yx - p1; end
        qte_pkg::MUL_XY: acc_yy <= acc_yy + p2;
        qte_pkg::MUL_WZ: acc_yy <= acc_yy + p2;
        qte_pkg::MUL_WW: acc_yx <= acc_yx + p1;
        qte_pkg::MUL_ZZ: acc_yx <= acc_yx - p1;
        default: ;
      endcase
    end
  end

  // floor square root of 1 - s*s, two bits a step
  logic [qte_pkg::SQW-1:0] sq_n, sq_res, sq_bit, sq_sum;
  assign sq_sum = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (tag_v && mul_tag == qte_pkg::MUL_SS) begin
      sq_n   <= (qte_pkg::SQW'(1) << 60) - prod[qte_pkg::SQW-1:0];
      sq_res <= '0;
      sq_bit <= qte_pkg::SQW'(1) << 60;
    end else if (cmd.sqrt_step) begin
      if (sq_n >= sq_sum) begin
        sq_n   <= sq_n - sq_sum;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // CORDIC start vector
  logic signed [CW-1:0] x0, y0;
  always_comb begin
    unique case (cmd.angle)
      qte_pkg::ANG_PITCH: begin
        y0 = {{(CW-32){s_cl[31]}}, s_cl};
        x0 = {{(CW-31){1'b0}}, sq_res[30:0]};
      end
      qte_pkg::ANG_ROLL: begin
        y0 = {{(CW-AW){acc_ry[AW-1]}}, acc_ry};
        x0 = {{(CW-AW){acc_rx[AW-1]}}, acc_rx};
      end
      qte_pkg::ANG_YAW: begin
        y0 = {{(CW-AW){acc_yy[AW-1]}}, acc_yy};
        x0 = {{(CW-AW){acc_yx[AW-1]}}, acc_yx};
      end
      default: begin
        y0 = '0;
        x0 = '0;
      end
    endcase
  end

  // CORDIC vectoring, one step a cycle
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz, atan_k;
  logic                 c_zero;
  assign atan_k = qte_pkg::atan_entry(cmd.cordic_k);

  always_ff @(posedge clk) begin
    if (cmd.cordic_load) begin
      c_zero <= (x0 == '0) && (y0 == '0);
      if (x0 < 0) begin
        cx <= -x0;
        cy <= -y0;
        cz <= (y0 >= 0) ? qte_pkg::PI_Q30 : -qte_pkg::PI_Q30;
      end else begin
        cx <= x0;
        cy <= y0;
        cz <= '0;
      end
    end else if (cmd.cordic_step && !c_zero) begin
      if (cy > 0) begin
        cx <= cx + (cy >>> cmd.cordic_k);
        cy <= cy - (cx >>> cmd.cordic_k);
        cz <= cz + atan_k;
      end else begin
        cx <= cx - (cy >>> cmd.cordic_k);
        cy <= cy + (cx >>> cmd.cordic_k);
        cz <= cz - atan_k;
      end
    end
  end

  // radians to 1/256 degree: round(|z| * 146688 / (10 * 2^30))
  logic                       z_neg, d_neg;
  logic [ZW-1:0]              z_mag;
  logic [qte_pkg::DTW-1:0]    dt;
  logic [qte_pkg::DRW-1:0]    dr;
  logic [20:0]                dq, lim;
  logic [16:0]                d_sat;
  logic signed [16:0]         d_val;

  assign z_neg = cz < 0;
  assign z_mag = z_neg ? ZW'(-cz) : ZW'(cz);

  always_ff @(posedge clk) begin
    if (cmd.deg1) begin
      dt    <= qte_pkg::DTW'(z_mag) * qte_pkg::DTW'(qte_pkg::DEG_NUM) + qte_pkg::DEG_HALF;
      d_neg <= z_neg;
    end
    if (cmd.deg2) begin
      dr <= qte_pkg::DRW'(dt[qte_pkg::DTW-1:30]) * qte_pkg::DRW'(qte_pkg::RECIP10);
    end
  end

  // divide by ten, saturate, restore sign
  assign dq    = dr[qte_pkg::DRW-1:23];
  assign lim   = {4'b0000, (cmd.angle == qte_pkg::ANG_PITCH) ? qte_pkg::PITCH_LIM
                                                             : qte_pkg::ANGLE_LIM};
  assign d_sat = (dq > lim) ? lim[16:0] : dq[16:0];
  assign d_val = d_neg ? -signed'(d_sat) : signed'(d_sat);

  // held angles
  logic signed [15:0] held_pitch;
  logic signed [16:0] held_roll, held_yaw;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_pitch <= '0;
      held_roll  <= '0;
      held_yaw   <= '0;
    end else if (cmd.deg3) begin
      unique case (cmd.angle)
        qte_pkg::ANG_PITCH: held_pitch <= d_val[15:0];
        qte_pkg::ANG_ROLL:  held_roll  <= d_val;
        qte_pkg::ANG_YAW:   held_yaw   <= d_val;
        default: ;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pitch_deg <= held_pitch;
      roll_deg  <= held_roll;
      yaw_deg   <= held_yaw;
    end
  end

endmodule

// ===== sv/quaternion_to_euler_angles.sv =====
// Quaternion (Q30) to ZYX Euler angles in 1/256 degree.
// Usage:
//   Input channel in_valid/in_ready carries one word: quat_present and the
//   four Q30 components. With quat_present low the last angles are sent again.
//   Output channel out_valid/out_ready carries pitch_deg, roll_deg, yaw_deg.
// Sequence (N = CORDIC_STEPS):
//   With a quaternion, the shared multiplier forms its products, then a drain
//   state, 31 square root steps, then per angle one CORDIC load, N CORDIC
//   steps and 3 scaling steps; the held angles then go to the output register.
//   Without one, the block goes straight to loading the held angles.
//   One word in flight; in_ready is high again in the cycle after the result is
//   loaded into the output register, so a new word is taken only after that.
// Reset (rst, synchronous): held angles cleared to zero, output empty.
// Stall: a result waiting on out_ready holds; the next input word is still
//   taken and computed, and waits for the output register to free up.
// Depends on qte_pkg, qte_ctrl, qte_dp.
`timescale 1ns / 1ps
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               quat_present,
  input  logic signed [31:0] quat_w,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pitch_deg,
  output logic signed [16:0] roll_deg,
  output logic signed [16:0] yaw_deg
);

  qte_pkg::dp_cmd_t cmd;

  qte_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .quat_present (quat_present),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  qte_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .pitch_deg (pitch_deg),
    .roll_deg  (roll_deg),
    .yaw_deg   (yaw_deg)
  );

endmodule

// ===== sim/quaternion_to_euler_angles_tb.sv =====
// Testbench for quaternion_to_euler_angles: directed and random Q30 samples,
// angles predicted in integer arithmetic. Depends on the block and qte_pkg.
`timescale 1ns / 1ps
module quaternion_to_euler_angles_tb;

  localparam int STEPS = 24;
  localparam longint ONE = 64'sd1073741824;
  localparam longint PI_RAD = 64'sd3373259426;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    bit present;
    logic signed [31:0] w, x, y, z;
  } sample_t;

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [16:0] roll;
    logic signed [16:0] yaw;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic quat_present = 1'b0;
  logic signed [31:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] pitch_deg;
  logic signed [16:0] roll_deg;
  logic signed [16:0] yaw_deg;

  sample_t pending_samples[$];
  angles_t expected_angles[$];
  longint held_pitch, held_roll, held_yaw;
  int error_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int cycle_count = 0;
  bit pause_req = 1'b0;
  bit quiet_tail = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .quat_present(quat_present),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .pitch_deg(pitch_deg), .roll_deg(roll_deg), .yaw_deg(yaw_deg)
  );

  always #5 clk = ~clk;

  // floor shift right
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return floor_shr(a * b, 30);
  endfunction

  function automatic longint atan_q30(int k);
    case (k)
      0: return 64'h3243F6A8;  1: return 64'h1DAC6705;
      2: return 64'h0FADBAFC;  3: return 64'h07F56EA6;
      4: return 64'h03FEAB76;  5: return 64'h01FFD55B;
      6: return 64'h00FFFAAA;  7: return 64'h007FFF55;
      8: return 64'h003FFFEA;  9: return 64'h001FFFFD;
      10: return 64'h000FFFFF; 11: return 64'h0007FFFF;
      12: return 64'h0003FFFF; 13: return 64'h0001FFFF;
      14: return 64'h0000FFFF; 15: return 64'h00007FFF;
      16: return 64'h00003FFF; 17: return 64'h00001FFF;
      18: return 64'h00000FFF; 19: return 64'h000007FF;
      20: return 64'h000003FF; 21: return 64'h000001FF;
      22: return 64'h000000FF; 23: return 64'h0000007F;
      24: return 64'h0000003F; 25: return 64'h0000001F;
      26: return 64'h0000000F; 27: return 64'h00000007;
      28: return 64'h00000003; 29: return 64'h00000001;
      default: return 0;
    endcase
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring CORDIC, Q30 radians
  function automatic longint vector_angle(longint vy, longint vx);
    longint ang, nx, ny;
    ang = 0;
    if (vx == 0 && vy == 0) return 0;
    if (vx < 0) begin
      ang = (vy >= 0) ? PI_RAD : -PI_RAD;
      vx = -vx;
      vy = -vy;
    end
    for (int k = 0; k < STEPS; k++) begin
      if (vy > 0) begin
        nx = vx + floor_shr(vy, k);
        ny = vy - floor_shr(vx, k);
        ang += atan_q30(k);
      end else begin
        nx = vx - floor_shr(vy, k);
        ny = vy + floor_shr(vx, k);
        ang -= atan_q30(k);
      end
      vx = nx;
      vy = ny;
    end
    return ang;
  endfunction

  // radians Q30 to 1/256 degree, round half away, saturate
  function automatic longint rad_to_deg(longint a, longint lim);
    longint unsigned mag;
    mag = (a < 0) ? longint'(-a) : a;
    mag = (mag * 64'd146688 + 64'd5368709120) / 64'd10737418240;
    if (mag > lim) mag = lim;
    return (a < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic angles_t predict_angles(sample_t s);
    longint w, x, y, z, sn, cs, ry, rx, yy, yx;
    longint unsigned m;
    angles_t r;
    if (s.present) begin
      w = s.w; x = s.x; y = s.y; z = s.z;
      sn = 2 * (q30_mul(w, y) - q30_mul(x, z));
      if (sn > ONE) sn = ONE;
      if (sn < -ONE) sn = -ONE;
      m = (sn < 0) ? -sn : sn;
      cs = floor_sqrt(64'd1152921504606846976 - m * m);
      held_pitch = rad_to_deg(vector_angle(sn, cs), 23100);
      ry = 2 * (q30_mul(y, z) + q30_mul(w, x));
      rx = ONE - 2 * q30_mul(x, x) - 2 * q30_mul(y, y);
      held_roll = rad_to_deg(vector_angle(ry, rx), 46100);
      yy = 2 * (q30_mul(x, y) + q30_mul(w, z));
      yx = q30_mul(w, w) + q30_mul(x, x) - q30_mul(y, y) - q30_mul(z, z);
      held_yaw = rad_to_deg(vector_angle(yy, yx), 46100);
    end
    r.pitch = held_pitch[15:0];
    r.roll = held_roll[16:0];
    r.yaw = held_yaw[16:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH word %0d %s: got %0d expected %0d", words_checked, what, got, want);
    error_count++;
  endtask

  function automatic sample_t make_sample(bit p, int w, int x, int y, int z);
    sample_t s;
    s.present = p; s.w = w; s.x = x; s.y = y; s.z = z;
    return s;
  endfunction

  // random unit-ish quaternion component, sometimes extreme
  function automatic int rand_comp();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2: return 0;
      default: return int'($urandom_range(0, 1 << 31)) - (1 << 30);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    sample_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) words_sent++;
      if (pending_samples.size() != 0 && !pause_req && send_gap == 0 &&
          (quiet_tail || $urandom_range(0, 5) != 0)) begin
        s = pending_samples.pop_front();
        expected_angles.push_back(predict_angles(s));
        in_valid <= 1'b1;
        quat_present <= s.present;
        quat_w <= s.w; quat_x <= s.x; quat_y <= s.y; quat_z <= s.z;
      end else begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (!quiet_tail && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 3);
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin
    angles_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          e = expected_angles.pop_front();
          if (pitch_deg !== e.pitch) report_mismatch("pitch", pitch_deg, e.pitch);
          if (roll_deg !== e.roll) report_mismatch("roll", roll_deg, e.roll);
          if (yaw_deg !== e.yaw) report_mismatch("yaw", yaw_deg, e.yaw);
        end
        words_checked++;
      end
      if (quiet_tail) begin
        out_ready <= 1'b1;
      end else if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if ($urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        recv_gap <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int k;
    held_pitch = 0; held_roll = 0; held_yaw = 0;
    // directed: hold after reset, identity, extremes, gimbal lock, zero
    pending_samples.push_back(make_sample(0, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(1, 1 << 30, 0, 0, 0));
    pending_samples.push_back(make_sample(1, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(1, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                          32'sh7FFFFFFF, 32'sh7FFFFFFF));
    pending_samples.push_back(make_sample(1, 32'sh80000000, 32'sh80000000,
                                          32'sh80000000, 32'sh80000000));
    pending_samples.push_back(make_sample(1, 759250125, 0, 759250125, 0));
    pending_samples.push_back(make_sample(1, 759250125, 0, -759250125, 0));
    pending_samples.push_back(make_sample(1, 0, 1 << 30, 0, 0));
    pending_samples.push_back(make_sample(1, 0, 0, 0, 1 << 30));
    pending_samples.push_back(make_sample(1, 0, 0, 0, -(1 << 30)));
    pending_samples.push_back(make_sample(1, 759250125, -759250125, 0, 0));
    pending_samples.push_back(make_sample(1, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 0));
    pending_samples.push_back(make_sample(1, 1 << 30, 0, 0, -1));
    pending_samples.push_back(make_sample(0, 32'sh7FFFFFFF, -1, 5, 32'sh80000000));
    pending_samples.push_back(make_sample(1, -(1 << 30), 12345, -98765, 1));
    pending_samples.push_back(make_sample(0, 0, 0, 0, 0));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // wait for everything, then pause the sender while the random samples are queued
    wait (pending_samples.size() == 0 && expected_angles.size() == 0 && !in_valid);
    pause_req = 1'b1;
    for (k = 0; k < 500; k++)
      pending_samples.push_back(make_sample($urandom_range(0, 7) != 0,
                                rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    pause_req = 1'b0;
    wait (pending_samples.size() == 0);
    quiet_tail = 1'b1;
    for (k = 0; k < 40; k++)
      pending_samples.push_back(make_sample($urandom_range(0, 3) != 0,
                                rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    wait (pending_samples.size() == 0 && expected_angles.size() == 0 && !in_valid);
    repeat (200) @(posedge clk);
    $display("Checked %0d result words from %0d samples, including hold, clamp and",
             words_checked, words_sent);
    $display("half-turn cases, with random stalls on both channels.");
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== quaternion_to_euler_angles.f =====
+incdir+sv
sv/qte_pkg.sv
sv/qte_ctrl.sv
sv/qte_dp.sv
sv/quaternion_to_euler_angles.sv
sim/quaternion_to_euler_angles_tb.sv
